### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/mlsc_pkg.sv
// Package for the majority-clocked LFSR stream cipher.
// Holds register widths, tap positions, key split and the state type.
package mlsc_pkg;

    localparam int unsigned KeyW   = 64;
    localparam int unsigned XW     = 19;
    localparam int unsigned YW     = 22;
    localparam int unsigned ZW     = 23;
    localparam int unsigned YKeyOfs = XW;
    localparam int unsigned ZKeyOfs = XW + YW;

    // Clock bits used for the majority vote.
    localparam int unsigned XClk = 8;
    localparam int unsigned YClk = 10;
    localparam int unsigned ZClk = 10;

    typedef logic [KeyW-1:0] t_key;

    typedef struct packed {
        logic [XW-1:0] x;
        logic [YW-1:0] y;
        logic [ZW-1:0] z;
    } t_lfsr_state;

    function automatic logic [XW-1:0] shift_x(input logic [XW-1:0] r);
        logic fb;
        fb = r[13] ^ r[16] ^ r[17] ^ r[18];
        return {r[XW-2:0], fb};
    endfunction

    function automatic logic [YW-1:0] shift_y(input logic [YW-1:0] r);
        logic fb;
        fb = r[20] ^ r[21];
        return {r[YW-2:0], fb};
    endfunction

    function automatic logic [ZW-1:0] shift_z(input logic [ZW-1:0] r);
        logic fb;
        fb = r[7] ^ r[20] ^ r[21] ^ r[22];
        return {r[ZW-2:0], fb};
    endfunction

endpackage

### hw/rtl/mlsc_step.sv
// One keystream step: optional reload from the key, majority clocking,
// and the output bit. Purely combinational; depends on mlsc_pkg.
module mlsc_step (
    input  mlsc_pkg::t_lfsr_state i_state,
    input  mlsc_pkg::t_key        i_key,
    input  logic                  i_data_bit,
    input  logic                  i_first_of_message,
    output mlsc_pkg::t_lfsr_state o_state,
    output logic                  o_out_bit
);
    import mlsc_pkg::*;

    t_lfsr_state cur;
    logic        cx, cy, cz, maj;

    always_comb begin
        if (i_first_of_message) begin
            cur.x = i_key[XW-1:0];
            cur.y = i_key[YKeyOfs +: YW];
            cur.z = i_key[ZKeyOfs +: ZW];
        end else begin
            cur = i_state;
        end

        cx  = cur.x[XClk];
        cy  = cur.y[YClk];
        cz  = cur.z[ZClk];
        maj = (cx & cy) | (cx & cz) | (cy & cz);

        o_state.x = (cx == maj) ? shift_x(cur.x) : cur.x;
        o_state.y = (cy == maj) ? shift_y(cur.y) : cur.y;
        o_state.z = (cz == maj) ? shift_z(cur.z) : cur.z;

        // Keystream is taken from the registers after clocking.
        o_out_bit = o_state.x[XW-1] ^ o_state.y[YW-1] ^ o_state.z[ZW-1] ^ i_data_bit;
    end

endmodule

### hw/rtl/majority_clocked_lfsr_stream_cipher.sv
// Each input transaction passes through the input register and then the result register.
// Throughput: one bit per cycle while the output side does not stall; the LFSR step is a single combinational pass.
// The input side stalls only while a result is held and the output side stalls.
// Reset (i_rst_n low, synchronous) clears the key, all three LFSRs and both valid flags.
// Key writes are always ready and take effect at the next first-of-message bit.
module majority_clocked_lfsr_stream_cipher (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  mlsc_pkg::t_key      i_cipher_key,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_data_bit,
    input  logic                i_first_of_message,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_out_bit
);
    import mlsc_pkg::*;

    t_key        r_key;
    t_lfsr_state r_state, n_state;
    logic        r_in_valid, r_data, r_first;
    logic        r_out_valid, r_out_bit, n_out_bit;
    logic        out_free, fire, in_accept;

    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign fire        = r_in_valid && out_free;
    assign o_in_stall  = r_in_valid && !out_free;
    assign in_accept   = i_in_valid && !o_in_stall;

    mlsc_step u_step (
        .i_state            (r_state),
        .i_key              (r_key),
        .i_data_bit         (r_data),
        .i_first_of_message (r_first),
        .o_state            (n_state),
        .o_out_bit          (n_out_bit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key       <= '0;
            r_state     <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_key <= i_cipher_key;
            end
            if (fire) begin
                r_state <= n_state;
            end
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_data  <= i_data_bit;
            r_first <= i_first_of_message;
        end
        if (fire) begin
            r_out_bit <= n_out_bit;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_bit   = r_out_bit;

endmodule

### hw/rtl/mlsc_checker.sv
// Port-level checker for the stream cipher top level, attached by bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module mlsc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_cfg_ready,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_out_bit
);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_bit), "stalled result changed")
    `ASSERT_IMPLY(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall, "input stalled with free output")
    `ASSERT_IMPLY(a_cfg_ready, i_clk, i_rst_n, 1'b1, o_cfg_ready, "key write not ready")

endmodule

bind majority_clocked_lfsr_stream_cipher mlsc_checker u_mlsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_cfg_ready (o_cfg_ready),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_bit   (o_out_bit)
);
